### design/signed_mul_div_rem_unit_defines.svh
// assertion helpers used by the unit's controller
`ifndef SIGNED_MUL_DIV_REM_UNIT_DEFINES_SVH
`define SIGNED_MUL_DIV_REM_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SMDR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SMDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/smdr_pkg.sv
`timescale 1ns / 1ps

package smdr_pkg;

    localparam logic [1:0] MODE_MUL = 2'd0;
    localparam logic [1:0] MODE_DIV = 2'd1;
    localparam logic [1:0] MODE_REM = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

### design/smdr_if.sv
`timescale 1ns / 1ps

interface smdr_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input mode, input operand_a, input operand_b,
                    output ready);
endinterface

interface smdr_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         divide_by_zero;

    modport source (output valid, output result, output divide_by_zero, input ready);
    modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

### design/signed_mul_div_rem_unit.sv
`timescale 1ns / 1ps
// an input transfer is accepted only while idle, then the shift-add / shift-subtract loop
// handles one operand bit per cycle, then a sign fix-up step writes the output register
// and the result turns valid; fix-up waits while the output holds an untaken result
// the output register holds a result until taken while the next item iterates
// reset (i_rst_n, synchronous, active low) idles the controller and empties the output

module signed_mul_div_rem_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smdr_in_if.sink      i_in,
    smdr_out_if.source   o_out
);

    smdr_pkg::t_dp_cmd cmd;
    smdr_pkg::t_dp_sts sts;

    smdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    smdr_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_in.mode),
        .i_operand_a      (i_in.operand_a),
        .i_operand_b      (i_in.operand_b),
        .o_result         (o_out.result),
        .o_divide_by_zero (o_out.divide_by_zero)
    );

endmodule

### design/smdr_dp.sv
`timescale 1ns / 1ps

module smdr_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smdr_pkg::t_dp_cmd            i_cmd,
    output smdr_pkg::t_dp_sts            o_sts,
    input  logic [1:0]                   i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_divide_by_zero
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [1:0]            r_mode;
    logic [DATA_WIDTH-1:0] r_a;      // multiplier, or dividend then quotient
    logic [DATA_WIDTH-1:0] r_b;      // multiplicand or divisor magnitude
    logic [DATA_WIDTH-1:0] r_acc;    // product or partial remainder
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg_q;
    logic                  r_neg_r;
    logic                  r_dz;
    logic [DATA_WIDTH-1:0] r_res;
    logic                  r_res_dz;

    logic                  a_neg;
    logic                  b_neg;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic                  is_div_op;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] n_res;

    assign a_neg     = i_operand_a[DATA_WIDTH-1];
    assign b_neg     = i_operand_b[DATA_WIDTH-1];
    assign a_mag     = a_neg ? (DATA_WIDTH'(0) - i_operand_a) : i_operand_a;
    assign b_mag     = b_neg ? (DATA_WIDTH'(0) - i_operand_b) : i_operand_b;
    assign is_div_op = (i_mode == smdr_pkg::MODE_DIV) || (i_mode == smdr_pkg::MODE_REM);

    // restoring divide step: shift next dividend bit into remainder, try subtract
    assign rem_sh = {r_acc, r_a[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_b};

    always_comb begin
        n_res = '0;
        case (r_mode)
            smdr_pkg::MODE_MUL: n_res = r_acc;
            smdr_pkg::MODE_DIV: n_res = r_dz ? '0 : (r_neg_q ? (DATA_WIDTH'(0) - r_a) : r_a);
            smdr_pkg::MODE_REM: n_res = r_dz ? '0 :
                                        (r_neg_r ? (DATA_WIDTH'(0) - r_acc) : r_acc);
            default:            n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= CNT_W'(DATA_WIDTH - 1);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_acc   <= '0;
            r_neg_q <= a_neg ^ b_neg;
            r_neg_r <= a_neg;
            r_dz    <= is_div_op && (i_operand_b == '0);
            if (i_mode == smdr_pkg::MODE_MUL) begin
                r_a <= i_operand_a;
                r_b <= i_operand_b;
            end else begin
                r_a <= a_mag;
                r_b <= b_mag;
            end
        end else if (i_cmd.step) begin
            if (r_mode == smdr_pkg::MODE_MUL) begin
                if (r_a[0]) begin
                    r_acc <= r_acc + r_b;
                end
                r_a <= r_a >> 1;
                r_b <= r_b << 1;
            end else if (!diff[DATA_WIDTH]) begin
                r_acc <= diff[DATA_WIDTH-1:0];
                r_a   <= {r_a[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_acc <= rem_sh[DATA_WIDTH-1:0];
                r_a   <= {r_a[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_res    <= n_res;
            r_res_dz <= r_dz;
        end
    end

    assign o_sts.last       = (r_cnt == '0);
    assign o_result         = r_res;
    assign o_divide_by_zero = r_res_dz;

endmodule

### design/smdr_ctrl.sv
`timescale 1ns / 1ps
`include "signed_mul_div_rem_unit_defines.svh"

module smdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output smdr_pkg::t_dp_cmd o_cmd,
    input  smdr_pkg::t_dp_sts i_sts
);

    smdr_pkg::t_state r_state;
    smdr_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smdr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = smdr_pkg::ST_RUN;
                end
            end
            smdr_pkg::ST_RUN: begin
                if (i_sts.last) begin
                    n_state = smdr_pkg::ST_FIX;
                end
            end
            smdr_pkg::ST_FIX: begin
                if (out_free) begin
                    n_state = smdr_pkg::ST_IDLE;
                end
            end
            default: n_state = smdr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            smdr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            smdr_pkg::ST_RUN: begin
                o_cmd.step = 1'b1;
            end
            smdr_pkg::ST_FIX: begin
                o_cmd.fix = out_free;
            end
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fix) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smdr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SMDR_ASSERT_NEXT(a_accept_starts_run, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == smdr_pkg::ST_RUN, "accepted transfer did not start iteration")
    `SMDR_ASSERT_IMPL(a_fix_needs_room, i_clk, i_rst_n, o_cmd.fix, out_free, "result written over an untaken transfer")
    `SMDR_ASSERT_NEXT(a_last_step_fixes, i_clk, i_rst_n, r_state == smdr_pkg::ST_RUN && i_sts.last, r_state == smdr_pkg::ST_FIX, "iteration did not end on last step")
    `SMDR_ASSERT_IMPL(a_one_command, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "datapath given more than one command")

endmodule

### dv/tb_signed_mul_div_rem_unit.sv
`timescale 1ns / 1ps

module tb_signed_mul_div_rem_unit;

    localparam int DATA_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int END_DRAIN   = DATA_WIDTH + 8;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word result;
        logic  divide_by_zero;
    } t_mdr_result;

    localparam t_word WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_word WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic clk;
    logic rst_n;

    smdr_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_if ();
    smdr_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_if ();

    signed_mul_div_rem_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_mdr_result pending_results[$];
    int          fail_count;
    int          cycle_count;
    bit          gaps_on;
    int          hold_left;
    int          stall_left;

    always #4 clk = ~clk;

    // signed multiply / truncated divide / dividend-signed remainder
    function automatic t_mdr_result predict_result(logic [1:0] mode, t_word a, t_word b);
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] rem;
        t_mdr_result           res;
        res   = '0;
        mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        case (mode) inside
            smdr_pkg::MODE_MUL: begin
                res.result = a * b;
            end
            smdr_pkg::MODE_DIV, smdr_pkg::MODE_REM: begin
                if (b == '0) begin
                    res.divide_by_zero = 1'b1;
                end else begin
                    quo = mag_a / mag_b;
                    rem = mag_a % mag_b;
                    if (mode == smdr_pkg::MODE_DIV) begin
                        res.result = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? (~quo + 1'b1) : quo;
                    end else begin
                        res.result = a[DATA_WIDTH-1] ? (~rem + 1'b1) : rem;
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // mix of full-range, small, boundary and power-of-two operands
    function automatic t_word pick_operand();
        t_word v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = $signed($urandom_range(0, 40)) - 20;
            3:    v = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
            4:    v = t_word'(1) << $urandom_range(0, DATA_WIDTH - 1);
            default: v = $urandom_range(0, 2) == 0 ? t_word'(0) :
                         ($urandom_range(0, 1) ? t_word'(1) : t_word'(-1));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [1:0] pick_mode();
        logic [1:0] modes [3];
        modes = '{smdr_pkg::MODE_MUL, smdr_pkg::MODE_DIV, smdr_pkg::MODE_REM};
        return modes[$urandom_range(0, 2)];
    endfunction

    // holds the item until the transfer; valid stays high into the next call
    task automatic send_op(logic [1:0] mode, t_word a, t_word b, bit allow_gap);
        int gap;
        @(negedge clk);
        if (allow_gap && gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid     = 1'b1;
        in_if.mode      = mode;
        in_if.operand_a = a;
        in_if.operand_b = b;
        do begin
            @(posedge clk);
        end while (!in_if.ready);
        pending_results.push_back(predict_result(mode, a, b));
    endtask

    task automatic release_input();
        @(negedge clk);
        in_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        send_op(smdr_pkg::MODE_MUL, WORD_MIN, WORD_MIN, 1'b1);
        send_op(smdr_pkg::MODE_MUL, WORD_MAX, WORD_MAX, 1'b1);
        send_op(smdr_pkg::MODE_MUL, WORD_MIN, -1, 1'b1);
        send_op(smdr_pkg::MODE_MUL, -1, -1, 1'b1);
        send_op(smdr_pkg::MODE_MUL, 0, WORD_MAX, 1'b1);
        send_op(smdr_pkg::MODE_MUL, -12345, 6789, 1'b1);
        send_op(smdr_pkg::MODE_DIV, 100, 0, 1'b1);
        send_op(smdr_pkg::MODE_DIV, 0, 0, 1'b1);
        send_op(smdr_pkg::MODE_DIV, WORD_MIN, -1, 1'b1);
        send_op(smdr_pkg::MODE_DIV, WORD_MIN, 1, 1'b1);
        send_op(smdr_pkg::MODE_DIV, WORD_MAX, -1, 1'b1);
        send_op(smdr_pkg::MODE_DIV, -7, 2, 1'b1);
        send_op(smdr_pkg::MODE_DIV, 7, -2, 1'b1);
        send_op(smdr_pkg::MODE_DIV, -7, -2, 1'b1);
        send_op(smdr_pkg::MODE_DIV, WORD_MIN, WORD_MIN, 1'b1);
        send_op(smdr_pkg::MODE_DIV, 5, WORD_MIN, 1'b1);
        send_op(smdr_pkg::MODE_REM, WORD_MIN, 0, 1'b1);
        send_op(smdr_pkg::MODE_REM, WORD_MIN, -1, 1'b1);
        send_op(smdr_pkg::MODE_REM, -7, 2, 1'b1);
        send_op(smdr_pkg::MODE_REM, 7, -2, 1'b1);
        send_op(smdr_pkg::MODE_REM, WORD_MIN, WORD_MAX, 1'b1);
        send_op(smdr_pkg::MODE_REM, WORD_MAX, WORD_MIN, 1'b1);
        send_op(smdr_pkg::MODE_REM, WORD_MIN, 3, 1'b1);
        send_op(smdr_pkg::MODE_REM, -1, WORD_MAX, 1'b1);
        release_input();
        wait_drained();
    endtask

    // result side blocked long enough that the unit fills and stalls its input
    task automatic test_backpressure();
        int n;
        @(posedge clk);
        hold_left = 300;
        for (n = 0; n < 8; n++) begin
            send_op(pick_mode(), pick_operand(), pick_operand(), 1'b0);
        end
        release_input();
        wait_drained();
    endtask

    task automatic test_random(int count, bit with_gaps);
        int n;
        gaps_on = with_gaps;
        for (n = 0; n < count; n++) begin
            send_op(pick_mode(), pick_operand(), pick_operand(), 1'b1);
        end
        release_input();
        wait_drained();
    endtask

    // result-side ready: long hold-off on request, otherwise random stall bursts while gaps are on
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            out_if.ready = 1'b0;
            stall_left   = $urandom_range(1, 5) - 1;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    always @(posedge clk) begin
        t_mdr_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result transfer: result=%0d divide_by_zero=%0b",
                             out_if.result, out_if.divide_by_zero);
                end
            end else begin
                want = pending_results.pop_front();
                if (out_if.result !== want.result ||
                    out_if.divide_by_zero !== want.divide_by_zero) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: result exp %0d got %0d, divide_by_zero exp %0b got %0b",
                                 want.result, out_if.result,
                                 want.divide_by_zero, out_if.divide_by_zero);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.mode      = smdr_pkg::MODE_MUL;
        in_if.operand_a = '0;
        in_if.operand_b = '0;
        out_if.ready    = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        gaps_on         = 1'b1;
        hold_left       = 0;
        stall_left      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(350, 1'b1);
        // closing stretch with no input gaps and the result side always ready
        test_random(150, 1'b0);

        repeat (END_DRAIN) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
